// ----- rtl/lbs_pkg.sv -----
// Types, codes and register layout shared by the lightmap sampler modules.
// No dependencies.
package lbs_pkg;

    localparam int IDX_W  = 8;
    localparam int FRAC_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic [5:0]         load_row;
        logic [5:0]         load_col;
        logic [7:0]         load_red;
        logic [7:0]         load_green;
        logic [7:0]         load_blue;
    } in_t;

    typedef struct packed {
        logic [23:0] red_out;
        logic [23:0] green_out;
        logic [23:0] blue_out;
    } out_t;

    typedef struct packed {
        logic signed [31:0] offset_u;
        logic signed [31:0] offset_v;
        logic [15:0]        scale_u;
        logic [15:0]        scale_v;
        logic [21:0]        limit_u;
        logic [21:0]        limit_v;
        logic [6:0]         map_columns;
        logic [6:0]         map_rows;
    } cfg_t;

    typedef struct packed {
        logic              is_sample;
        logic [IDX_W-1:0]  row0;
        logic [IDX_W-1:0]  row1;
        logic [IDX_W-1:0]  col0;
        logic [IDX_W-1:0]  col1;
        logic [FRAC_W-1:0] frac_u;
        logic [FRAC_W-1:0] frac_v;
        logic [23:0]       texel;
    } job_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_U    = 3'd0,
        CFG_OFFSET_V    = 3'd1,
        CFG_SCALE_U     = 3'd2,
        CFG_SCALE_V     = 3'd3,
        CFG_LIMIT_U     = 3'd4,
        CFG_LIMIT_V     = 3'd5,
        CFG_MAP_COLUMNS = 3'd6,
        CFG_MAP_ROWS    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SHIFT,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD0,
        B_RD1,
        B_RD2,
        B_RD3,
        B_WAIT,
        B_LERP1,
        B_LERP2
    } back_state_t;

endpackage

// ----- rtl/lbs_front.sv -----
// Front end: accepts beats, maps sample coordinates to texel indices and fractions.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic q_push,
    input  logic q_ready,
    output job_t q_data
);

    front_state_t state_reg, state_next;
    in_t in_reg;
    logic signed [24:0] su_reg, sv_reg;
    logic signed [41:0] pu_reg, pv_reg;
    logic load_ok;
    logic [21:0] lu, lv;
    logic [5:0] col0, row0;
    logic [6:0] col1, row1;

    function automatic logic [IDX_W-1:0] sat_idx(input logic [8:0] x, input int lim);
        logic [8:0] top;
        top = 9'(lim - 1);
        return (x > top) ? top[IDX_W-1:0] : x[IDX_W-1:0];
    endfunction

    function automatic logic [21:0] clamp(input logic signed [41:0] p, input logic [21:0] lim);
        logic [21:0] r;
        if (p < 0) r = '0;
        else if (p > $signed({20'b0, lim})) r = lim;
        else r = p[21:0];
        return r;
    endfunction

    assign load_ok = ({3'b0, s_data.load_row} < 9'(MAX_ROWS)) &&
                     ({3'b0, s_data.load_col} < 9'(MAX_COLUMNS));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    if (s_data.kind == KIND_SAMPLE) state_next = F_SHIFT;
                    else if (load_ok) state_next = F_PUSH;
                end
            end
            F_SHIFT: state_next = F_MUL;
            F_MUL:   state_next = F_PUSH;
            F_PUSH:  if (q_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        lu   = clamp(pu_reg, cfg.limit_u);
        lv   = clamp(pv_reg, cfg.limit_v);
        col0 = lu[21:16];
        row0 = lv[21:16];
        col1 = ({1'b0, col0} + 7'd1 < cfg.map_columns) ? {1'b0, col0} + 7'd1 : {1'b0, col0};
        row1 = ({1'b0, row0} + 7'd1 < cfg.map_rows) ? {1'b0, row0} + 7'd1 : {1'b0, row0};
        s_ready = (state_reg == F_IDLE);
        q_push  = (state_reg == F_PUSH);
        q_data  = '0;
        if (in_reg.kind == KIND_SAMPLE) begin
            q_data.is_sample = 1'b1;
            q_data.col0   = sat_idx({3'b0, col0}, MAX_COLUMNS);
            q_data.row0   = sat_idx({3'b0, row0}, MAX_ROWS);
            q_data.col1   = sat_idx({2'b0, col1}, MAX_COLUMNS);
            q_data.row1   = sat_idx({2'b0, row1}, MAX_ROWS);
            q_data.frac_u = lu[15:0];
            q_data.frac_v = lv[15:0];
        end else begin
            q_data.row0  = IDX_W'(in_reg.load_row);
            q_data.col0  = IDX_W'(in_reg.load_col);
            q_data.texel = {in_reg.load_blue, in_reg.load_green, in_reg.load_red};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (s_valid && s_ready) in_reg <= s_data;
        su_reg <= 25'((33'(in_reg.coord_u) - 33'(cfg.offset_u)) >>> 8);
        sv_reg <= 25'((33'(in_reg.coord_v) - 33'(cfg.offset_v)) >>> 8);
        pu_reg <= 42'(su_reg * $signed({1'b0, cfg.scale_u}));
        pv_reg <= 42'(sv_reg * $signed({1'b0, cfg.scale_v}));
    end

endmodule

// ----- rtl/lbs_queue.sv -----
// Two-entry job queue between front end and back end.
// Depends on lbs_pkg.
module lbs_queue import lbs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_data
);

    job_t slot_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && push_ready) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && pop_valid) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'((push && push_ready) ? 1 : 0)
                                   - 2'((pop && pop_valid) ? 1 : 0);
        end
        if (push && push_ready) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/lbs_back.sv -----
// Back end: texel memory, four-tap fetch, bilinear blend and output register.
// Depends on lbs_pkg.
module lbs_back import lbs_pkg::*; #(
    parameter int MAX_COLUMNS   = 64,
    parameter int MAX_ROWS      = 64,
    parameter int CHANNEL_SHIFT = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_pop,
    input  job_t q_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    back_state_t state_reg, state_next;
    job_t job_reg;
    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;
    logic [23:0] tex_reg [4];
    logic [7:0] top_reg [3];
    logic [7:0] bot_reg [3];
    logic out_valid_reg;
    out_t out_reg;
    logic mem_we, out_load;
    logic [AW-1:0] waddr, raddr;
    logic [IDX_W-1:0] rd_row, rd_col;
    logic [7:0] fin [3];
    out_t out_next;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_COLUMNS + int'(c));
    endfunction

    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [15:0] f);
        logic signed [8:0]  diff;
        logic signed [25:0] prod;
        logic signed [9:0]  sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b0, a}) + prod[25:16];
        return sum[7:0];
    endfunction

    function automatic logic [23:0] place(input logic [7:0] v);
        logic [31:0] w;
        w = 32'(v) << CHANNEL_SHIFT;
        return w[23:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid && q_data.is_sample) state_next = B_RD0;
            B_RD0:   state_next = B_RD1;
            B_RD1:   state_next = B_RD2;
            B_RD2:   state_next = B_RD3;
            B_RD3:   state_next = B_WAIT;
            B_WAIT:  state_next = B_LERP1;
            B_LERP1: state_next = B_LERP2;
            B_LERP2: if (!out_valid_reg || m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == B_IDLE) && q_valid;
        mem_we   = q_pop && !q_data.is_sample;
        waddr    = addr_of(q_data.row0, q_data.col0);
        out_load = (state_reg == B_LERP2) && (!out_valid_reg || m_ready);
        rd_row   = job_reg.row0;
        rd_col   = job_reg.col0;
        unique case (state_reg)
            B_RD1:   rd_col = job_reg.col1;
            B_RD2:   rd_row = job_reg.row1;
            B_RD3: begin
                rd_row = job_reg.row1;
                rd_col = job_reg.col1;
            end
            default: ;
        endcase
        raddr = addr_of(rd_row, rd_col);
        for (int ch = 0; ch < 3; ch++) begin
            fin[ch] = lerp8(top_reg[ch], bot_reg[ch], job_reg.frac_v);
        end
        out_next.red_out   = place(fin[0]);
        out_next.green_out = place(fin[1]);
        out_next.blue_out  = place(fin[2]);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= q_data.texel;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
        if (q_pop) job_reg <= q_data;
        if (state_reg == B_RD1) tex_reg[0] <= rdata_reg;
        if (state_reg == B_RD2) tex_reg[1] <= rdata_reg;
        if (state_reg == B_RD3) tex_reg[2] <= rdata_reg;
        if (state_reg == B_WAIT) tex_reg[3] <= rdata_reg;
        if (state_reg == B_LERP1) begin
            for (int ch = 0; ch < 3; ch++) begin
                top_reg[ch] <= lerp8(tex_reg[0][ch*8 +: 8], tex_reg[1][ch*8 +: 8], job_reg.frac_u);
                bot_reg[ch] <= lerp8(tex_reg[2][ch*8 +: 8], tex_reg[3][ch*8 +: 8], job_reg.frac_u);
            end
        end
        if (out_load) out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- rtl/lightmap_bilinear_sampler_unit.sv -----
// Top level of the bilinear lightmap sampler: registers, front end, queue, back end.
// Depends on lbs_pkg, lbs_front, lbs_queue, lbs_back.
//
//  channel  ports                      beat
//  input    s_valid s_ready s_data     one load or one sample
//  output   m_valid m_ready m_data     one filtered RGB result per sample
//  config   cfg_we cfg_index cfg_data  one register write, no wait
//
// The front end takes a sample through accept, shift, scale, clamp and push; the
// back end works on it in pop, four reads through the single texel memory read
// port, wait and two blend steps, and pops no new job until it is back in idle. A
// load holds the front end from acceptance to push and writes memory when the back
// end pops it.
// Reset clears control state only; texel memory holds garbage until loaded.
// A stalled output register holds the back end; the queue holds the front end.
module lightmap_bilinear_sampler_unit import lbs_pkg::*; #(
    parameter int MAX_COLUMNS   = 64,
    parameter int MAX_ROWS      = 64,
    parameter int CHANNEL_SHIFT = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    cfg_t cfg_reg;
    logic f_push, f_ready, b_valid, b_pop;
    job_t f_job, b_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_u    <= '0;
            cfg_reg.offset_v    <= '0;
            cfg_reg.scale_u     <= 16'd256;
            cfg_reg.scale_v     <= 16'd256;
            cfg_reg.limit_u     <= '0;
            cfg_reg.limit_v     <= '0;
            cfg_reg.map_columns <= 7'd64;
            cfg_reg.map_rows    <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OFFSET_U:    cfg_reg.offset_u    <= $signed(cfg_data);
                CFG_OFFSET_V:    cfg_reg.offset_v    <= $signed(cfg_data);
                CFG_SCALE_U:     cfg_reg.scale_u     <= cfg_data[15:0];
                CFG_SCALE_V:     cfg_reg.scale_v     <= cfg_data[15:0];
                CFG_LIMIT_U:     cfg_reg.limit_u     <= cfg_data[21:0];
                CFG_LIMIT_V:     cfg_reg.limit_v     <= cfg_data[21:0];
                CFG_MAP_COLUMNS: cfg_reg.map_columns <= cfg_data[6:0];
                CFG_MAP_ROWS:    cfg_reg.map_rows    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    lbs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_push(f_push), .q_ready(f_ready), .q_data(f_job)
    );

    lbs_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(f_push), .push_ready(f_ready), .push_data(f_job),
        .pop_valid(b_valid), .pop(b_pop), .pop_data(b_job)
    );

    lbs_back #(
        .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .CHANNEL_SHIFT(CHANNEL_SHIFT)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_pop(b_pop), .q_data(b_job),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        b_pop |-> b_valid) else $error("job popped from empty queue");

    a_push_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_push && !f_ready) |=> (f_push && $stable(f_job)))
        else $error("front end dropped a job while queue was full");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.kind == KIND_SAMPLE) |=> !s_ready)
        else $error("front end accepted while busy");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

endmodule
